// ===== sv/pfs_pkg.sv =====
// ----------------------------------------------------------------------------
// pfs_pkg
// shared constants, types and ring address helpers of the phase field stencil
// ----------------------------------------------------------------------------
package pfs_pkg;

   localparam int MAX_X = 64;
   localparam int MAX_Y = 64;
   localparam int MAX_Z = 1024;

   localparam int DEPTH  = 2 * MAX_X * MAX_Y + MAX_X;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int POS_W  = $clog2(MAX_X * MAX_Y * MAX_Z);
   localparam int TOT_W  = POS_W + 1;
   localparam int XY_W   = $clog2(MAX_X * MAX_Y + 1);
   localparam int XU_W   = $clog2(MAX_X + 1);
   localparam int YU_W   = $clog2(MAX_Y + 1);
   localparam int ZU_W   = $clog2(MAX_Z + 1);
   localparam int OX_W   = $clog2(MAX_X);
   localparam int OY_W   = $clog2(MAX_Y);
   localparam int OZ_W   = $clog2(MAX_Z);

   localparam int PHASE_W = 17;
   localparam int TEMP_W  = 24;
   localparam int GAIN_W  = 24;
   localparam int ENTRY_W = PHASE_W + TEMP_W;
   localparam int PSUM_W  = 19;
   localparam int TSUM_W  = 27;
   localparam int NUM_TAPS = 7;

   localparam logic [PHASE_W-1:0] PHASE_ONE = 17'd65536;

   // input beat kinds
   localparam logic KIND_CELL  = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // register indexes of the configuration port
   localparam logic [2:0] REG_GRID_X    = 3'd0;
   localparam logic [2:0] REG_GRID_Y    = 3'd1;
   localparam logic [2:0] REG_GRID_Z    = 3'd2;
   localparam logic [2:0] REG_THERMAL   = 3'd3;
   localparam logic [2:0] REG_GRADIENT  = 3'd4;
   localparam logic [2:0] REG_POTENTIAL = 3'd5;
   localparam logic [2:0] REG_DRIVING   = 3'd6;

   typedef struct packed {
      logic [GAIN_W-1:0] thermal;
      logic [GAIN_W-1:0] gradient;
      logic [GAIN_W-1:0] potential;
      logic [GAIN_W-1:0] driving;
   } gain_type;

   typedef struct packed {
      logic                     start;
      logic [PHASE_W-1:0]       pc;
      logic signed [TEMP_W-1:0] tc;
      logic [PSUM_W-1:0]        sp;
      logic signed [TSUM_W-1:0] st;
   } op_type;

   typedef struct packed {
      logic                     done;
      logic [PHASE_W-1:0]       phase;
      logic signed [TEMP_W-1:0] temp;
   } res_type;

   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] d);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + {1'b0, d};
      if (s >= (ADDR_W+1)'(DEPTH)) begin
         s = s - (ADDR_W+1)'(DEPTH);
      end
      return s[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] ring_sub(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] d);
      logic [ADDR_W:0] s;
      if (a >= d) begin
         s = {1'b0, a} - {1'b0, d};
      end else begin
         s = {1'b0, a} + (ADDR_W+1)'(DEPTH) - {1'b0, d};
      end
      return s[ADDR_W-1:0];
   endfunction

endpackage

// ===== sv/pfs_window_ram.sv =====
// ----------------------------------------------------------------------------
// pfs_window_ram
// window store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pfs_window_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [pfs_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [pfs_pkg::ENTRY_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [pfs_pkg::ADDR_W-1:0]  rd_addr,
   output logic [pfs_pkg::ENTRY_W-1:0] rd_data
);

   logic [pfs_pkg::ENTRY_W-1:0] mem [pfs_pkg::DEPTH];
   logic [pfs_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pfs_update.sv =====
// ----------------------------------------------------------------------------
// pfs_update
// cell update arithmetic: laplacians, gain products, bit-serial square root
// ----------------------------------------------------------------------------
module pfs_update (
   input  logic              clock,
   input  logic              reset,
   input  pfs_pkg::gain_type gain,
   input  pfs_pkg::op_type   op,
   output pfs_pkg::res_type  res
);

   typedef enum logic [6:0] {
      D_IDLE = 7'b0000001,
      D_MUL1 = 7'b0000010,
      D_SQRT = 7'b0000100,
      D_MUL2 = 7'b0001000,
      D_MUL3 = 7'b0010000,
      D_RND  = 7'b0100000,
      D_FIN  = 7'b1000000
   } dstate_type;

   localparam logic signed [52:0] HALF_T = 53'sd1 <<< 23;
   localparam logic signed [45:0] HALF_G = 46'sd1 <<< 23;
   localparam logic signed [42:0] HALF_P = 43'sd1 <<< 23;
   localparam logic signed [65:0] HALF_D = 66'sd1 <<< 39;

   dstate_type state_ff, state_in;

   logic [16:0]        pc_ff;
   logic signed [23:0] tc_ff;
   logic signed [20:0] lap_p_ff;
   logic signed [27:0] lap_t_ff;
   logic signed [52:0] prod_t_ff;
   logic signed [45:0] prod_g_ff;
   logic signed [42:0] prod_p_ff;
   logic [31:0]        arg_ff;
   logic [19:0]        rem_ff;
   logic [15:0]        root_ff;
   logic [3:0]         cnt_ff;
   logic [39:0]        prod_a_ff;
   logic signed [44:0] lo_ff, hi_ff;
   logic signed [29:0] rt_ff;
   logic signed [22:0] rg_ff;
   logic signed [19:0] rp_ff;
   logic signed [25:0] rd_ff;
   logic               done_ff;
   logic [16:0]        phase_ff;
   logic signed [23:0] temp_ff;

   logic [20:0]        pc6;
   logic signed [17:0] pot;
   logic [33:0]        sq_full;
   logic [19:0]        rem_sh, trial;
   logic signed [65:0] drive, drive_r;
   logic signed [52:0] t_r;
   logic signed [45:0] g_r;
   logic signed [42:0] p_r;
   logic signed [27:0] p_raw;
   logic [16:0]        p_cl;
   logic               active;
   logic signed [31:0] t_raw;
   logic signed [23:0] t_sat;

   assign pc6     = 21'(op.pc) * 21'd6;
   assign pot     = 18'sd32768 - $signed({1'b0, pc_ff});
   assign sq_full = 34'(pc_ff) * 34'(pfs_pkg::PHASE_ONE - pc_ff);
   assign rem_sh  = {rem_ff[17:0], arg_ff[31:30]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign drive   = (66'(hi_ff) <<< 20) + 66'(lo_ff);
   assign drive_r = drive + HALF_D;
   assign t_r     = prod_t_ff + HALF_T;
   assign g_r     = prod_g_ff + HALF_G;
   assign p_r     = prod_p_ff + HALF_P;
   assign active  = (lap_p_ff != 21'sd0);

   always_comb begin
      p_raw = 28'($signed({1'b0, pc_ff})) + 28'(rg_ff) - 28'(rp_ff) - 28'(rd_ff);
      if (p_raw < 28'sd0) begin
         p_cl = '0;
      end else if (p_raw > 28'sd65536) begin
         p_cl = pfs_pkg::PHASE_ONE;
      end else begin
         p_cl = p_raw[16:0];
      end
      t_raw = 32'(tc_ff) + 32'(rt_ff);
      if (active) begin
         t_raw = t_raw + 32'($signed({1'b0, p_cl})) - 32'($signed({1'b0, pc_ff}));
      end
      if (t_raw > 32'sd8388607) begin
         t_sat = 24'sh7fffff;
      end else if (t_raw < -32'sd8388608) begin
         t_sat = 24'sh800000;
      end else begin
         t_sat = t_raw[23:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         D_IDLE: if (op.start) state_in = D_MUL1;
         D_MUL1: state_in = D_SQRT;
         D_SQRT: if (cnt_ff == 4'd0) state_in = D_MUL2;
         D_MUL2: state_in = D_MUL3;
         D_MUL3: state_in = D_RND;
         D_RND:  state_in = D_FIN;
         D_FIN:  state_in = D_IDLE;
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == D_FIN);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         D_IDLE: begin
            pc_ff    <= op.pc;
            tc_ff    <= op.tc;
            lap_p_ff <= $signed(21'(op.sp)) - $signed(pc6);
            lap_t_ff <= 28'(op.st) - 28'(op.tc) * 28'sd6;
         end
         D_MUL1: begin
            prod_t_ff <= $signed({1'b0, gain.thermal}) * lap_t_ff;
            prod_g_ff <= $signed({1'b0, gain.gradient}) * lap_p_ff;
            prod_p_ff <= $signed({1'b0, gain.potential}) * pot;
            arg_ff    <= sq_full[31:0];
            rem_ff    <= '0;
            root_ff   <= '0;
            cnt_ff    <= 4'd15;
         end
         D_SQRT: begin
            // one result bit per cycle
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[14:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[14:0], 1'b0};
            end
            arg_ff <= {arg_ff[29:0], 2'b00};
            cnt_ff <= cnt_ff - 4'd1;
         end
         D_MUL2: prod_a_ff <= 40'(gain.driving) * 40'(root_ff);
         D_MUL3: begin
            lo_ff <= $signed({1'b0, prod_a_ff[19:0]}) * tc_ff;
            hi_ff <= $signed({1'b0, prod_a_ff[39:20]}) * tc_ff;
         end
         D_RND: begin
            rt_ff <= 30'(t_r >>> 24);
            rg_ff <= 23'(g_r >>> 24);
            rp_ff <= 20'(p_r >>> 24);
            rd_ff <= 26'(drive_r >>> 40);
         end
         D_FIN: begin
            phase_ff <= active ? p_cl : pc_ff;
            temp_ff  <= t_sat;
         end
         default: ;
      endcase
   end

   assign res.done  = done_ff;
   assign res.phase = phase_ff;
   assign res.temp  = temp_ff;

endmodule

// ===== sv/phase_field_stencil_step.sv =====
// ----------------------------------------------------------------------------
// phase_field_stencil_step
// 7-point phase field / temperature stencil update over a streamed 3d grid
// ----------------------------------------------------------------------------
// Cells arrive in raster order (x fastest) and are written into a ring window
// of two planes plus a row held in one single-port-read memory. Once the +z
// neighbour of a cell is in, that cell is updated, so results trail inputs by
// one plane plus one cell; flush beats drain the last plane. An input beat that
// writes no result does not hold the input off. A beat that produces a result
// holds the input off while the centre and six neighbours are read through
// the single read port (seven reads), while the update unit runs its multiply,
// bit-serial square root, rounding and hand-over stages, and until the result
// is passed to the output register, which waits while that register stalls.
// The finished result sits in the output register, so the next beat is taken
// while it waits. After a write to a grid size register the input stalls while
// the plane size and then the grid size settle; that write also restarts the
// grid. Window entries are only read once the current grid has written them.
// ----------------------------------------------------------------------------
module phase_field_stencil_step (
   input  logic                clock,
   input  logic                reset,
   // input beats
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [16:0]         req_phase_old,
   input  logic signed [23:0]  req_temp_old,
   // result beats
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [16:0]         rsp_phase_new,
   output logic signed [23:0]  rsp_temp_new,
   output logic                rsp_last_cell,
   // register writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [23:0]         csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_GATHER = 4'b0010,
      ST_MATH   = 4'b0100,
      ST_OUT    = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [6:0]                  grid_x_ff, grid_y_ff;
   logic [10:0]                 grid_z_ff;
   pfs_pkg::gain_type           gain_ff;
   logic [pfs_pkg::XY_W-1:0]    xy_ff;
   logic [pfs_pkg::TOT_W-1:0]   total_ff;
   logic [1:0]                  settle_ff;
   logic [pfs_pkg::XU_W-1:0]    x_used;
   logic [pfs_pkg::YU_W-1:0]    y_used;
   logic [pfs_pkg::ZU_W-1:0]    z_used;
   logic                        csr_wr, grid_wr;

   // positions
   logic [pfs_pkg::POS_W-1:0]   in_pos_ff, out_pos_ff;
   logic [pfs_pkg::ADDR_W-1:0]  in_addr_ff, out_addr_ff;
   logic [pfs_pkg::OX_W-1:0]    ox_ff;
   logic [pfs_pkg::OY_W-1:0]    oy_ff;
   logic [pfs_pkg::OZ_W-1:0]    oz_ff;
   logic [pfs_pkg::TOT_W-1:0]   in_next, out_next;

   // gather
   logic [pfs_pkg::ADDR_W-1:0]  tap_addr_ff [pfs_pkg::NUM_TAPS];
   logic [2:0]                  rd_cnt_ff, rd_tag_ff;
   logic                        rd_vld_ff;
   logic                        last_ff;
   logic [16:0]                 pc_ff;
   logic signed [23:0]          tc_ff;
   logic [pfs_pkg::PSUM_W-1:0]  sp_ff;
   logic signed [pfs_pkg::TSUM_W-1:0] st_ff;
   logic                        start_ff;

   // result register
   logic                        rsp_valid_ff;
   logic [16:0]                 rsp_phase_ff;
   logic signed [23:0]          rsp_temp_ff;
   logic                        rsp_last_ff;

   logic                        accept, complete, do_write, fire, wrap_out;
   logic                        is_cell;
   logic [16:0]                 ph_sat;
   logic                        rd_en;
   logic [pfs_pkg::ADDR_W-1:0]  rd_addr;
   logic [pfs_pkg::ENTRY_W-1:0] rd_data;
   logic signed [23:0]          rd_temp;
   logic                        out_free;
   pfs_pkg::op_type             op;
   pfs_pkg::res_type            res;

   // used grid sizes, saturated to [2, max]
   always_comb begin
      if (grid_x_ff < 7'd2) x_used = pfs_pkg::XU_W'(2);
      else if (grid_x_ff > 7'(pfs_pkg::MAX_X)) x_used = pfs_pkg::XU_W'(pfs_pkg::MAX_X);
      else x_used = pfs_pkg::XU_W'(grid_x_ff);
      if (grid_y_ff < 7'd2) y_used = pfs_pkg::YU_W'(2);
      else if (grid_y_ff > 7'(pfs_pkg::MAX_Y)) y_used = pfs_pkg::YU_W'(pfs_pkg::MAX_Y);
      else y_used = pfs_pkg::YU_W'(grid_y_ff);
      if (grid_z_ff < 11'd2) z_used = pfs_pkg::ZU_W'(2);
      else if (grid_z_ff > 11'(pfs_pkg::MAX_Z)) z_used = pfs_pkg::ZU_W'(pfs_pkg::MAX_Z);
      else z_used = pfs_pkg::ZU_W'(grid_z_ff);
   end

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;
   assign grid_wr   = csr_wr && (csr_index == pfs_pkg::REG_GRID_X ||
                                 csr_index == pfs_pkg::REG_GRID_Y ||
                                 csr_index == pfs_pkg::REG_GRID_Z);

   // input side decisions
   assign req_stall = (state_ff != ST_IDLE) || (settle_ff != 2'd0);
   assign accept    = req_valid & ~req_stall;
   assign is_cell   = (req_kind == pfs_pkg::KIND_CELL);
   assign complete  = (in_pos_ff == '0) && (out_pos_ff != '0);
   assign do_write  = accept && is_cell && !complete;
   assign in_next   = pfs_pkg::TOT_W'(in_pos_ff) + 1'b1;
   assign out_next  = pfs_pkg::TOT_W'(out_pos_ff) + 1'b1;
   // a result is due once the +z neighbour has arrived, or while draining
   assign fire      = accept && (complete ||
                      (is_cell && in_next > pfs_pkg::TOT_W'(xy_ff)));
   assign wrap_out  = complete && (out_next >= total_ff);
   assign ph_sat    = (req_phase_old > pfs_pkg::PHASE_ONE) ? pfs_pkg::PHASE_ONE
                                                           : req_phase_old;

   // register file and derived sizes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff         <= 7'd64;
         grid_y_ff         <= 7'd64;
         grid_z_ff         <= 11'd64;
         gain_ff.thermal   <= 24'd1870803;
         gain_ff.gradient  <= 24'd2516582;
         gain_ff.potential <= 24'd496753;
         gain_ff.driving   <= 24'd1581213;
         settle_ff         <= 2'd0;
         xy_ff             <= pfs_pkg::XY_W'(4096);
         total_ff          <= pfs_pkg::TOT_W'(262144);
      end else begin
         if (csr_wr) begin
            unique case (csr_index)
               pfs_pkg::REG_GRID_X:    grid_x_ff         <= csr_wdata[6:0];
               pfs_pkg::REG_GRID_Y:    grid_y_ff         <= csr_wdata[6:0];
               pfs_pkg::REG_GRID_Z:    grid_z_ff         <= csr_wdata[10:0];
               pfs_pkg::REG_THERMAL:   gain_ff.thermal   <= csr_wdata;
               pfs_pkg::REG_GRADIENT:  gain_ff.gradient  <= csr_wdata;
               pfs_pkg::REG_POTENTIAL: gain_ff.potential <= csr_wdata;
               pfs_pkg::REG_DRIVING:   gain_ff.driving   <= csr_wdata;
               default: ;
            endcase
         end
         // plane size then grid size follow a size write; the input stalls meanwhile
         if (grid_wr) settle_ff <= 2'd2;
         else if (settle_ff != 2'd0) settle_ff <= settle_ff - 2'd1;
         xy_ff    <= pfs_pkg::XY_W'(x_used) * pfs_pkg::XY_W'(y_used);
         total_ff <= pfs_pkg::TOT_W'(xy_ff) * pfs_pkg::TOT_W'(z_used);
      end
   end

   // neighbour addresses in the ring, edges fold back onto the centre
   always_ff @(posedge clock) begin
      if (fire) begin
         tap_addr_ff[0] <= out_addr_ff;
         tap_addr_ff[1] <= (ox_ff != '0) ?
                           pfs_pkg::ring_sub(out_addr_ff, pfs_pkg::ADDR_W'(1)) : out_addr_ff;
         tap_addr_ff[2] <= (pfs_pkg::XU_W'(ox_ff) + 1'b1 < x_used) ?
                           pfs_pkg::ring_add(out_addr_ff, pfs_pkg::ADDR_W'(1)) : out_addr_ff;
         tap_addr_ff[3] <= (oy_ff != '0) ?
                           pfs_pkg::ring_sub(out_addr_ff, pfs_pkg::ADDR_W'(x_used)) : out_addr_ff;
         tap_addr_ff[4] <= (pfs_pkg::YU_W'(oy_ff) + 1'b1 < y_used) ?
                           pfs_pkg::ring_add(out_addr_ff, pfs_pkg::ADDR_W'(x_used)) : out_addr_ff;
         tap_addr_ff[5] <= (oz_ff != '0) ?
                           pfs_pkg::ring_sub(out_addr_ff, pfs_pkg::ADDR_W'(xy_ff)) : out_addr_ff;
         tap_addr_ff[6] <= (pfs_pkg::ZU_W'(oz_ff) + 1'b1 < z_used) ?
                           pfs_pkg::ring_add(out_addr_ff, pfs_pkg::ADDR_W'(xy_ff)) : out_addr_ff;
         last_ff        <= (out_next == total_ff);
      end
   end

   // stream positions and ring pointers
   always_ff @(posedge clock) begin
      if (reset || grid_wr) begin
         in_pos_ff   <= '0;
         out_pos_ff  <= '0;
         in_addr_ff  <= '0;
         out_addr_ff <= '0;
         ox_ff       <= '0;
         oy_ff       <= '0;
         oz_ff       <= '0;
      end else begin
         if (do_write) begin
            if (in_next >= total_ff) begin
               in_pos_ff  <= '0;
               in_addr_ff <= '0;
            end else begin
               in_pos_ff  <= in_next[pfs_pkg::POS_W-1:0];
               in_addr_ff <= pfs_pkg::ring_add(in_addr_ff, pfs_pkg::ADDR_W'(1));
            end
         end
         if (fire) begin
            if (wrap_out) begin
               out_pos_ff  <= '0;
               out_addr_ff <= '0;
               ox_ff       <= '0;
               oy_ff       <= '0;
               oz_ff       <= '0;
            end else begin
               out_pos_ff  <= out_next[pfs_pkg::POS_W-1:0];
               out_addr_ff <= pfs_pkg::ring_add(out_addr_ff, pfs_pkg::ADDR_W'(1));
               if (pfs_pkg::XU_W'(ox_ff) + 1'b1 == x_used) begin
                  ox_ff <= '0;
                  if (pfs_pkg::YU_W'(oy_ff) + 1'b1 == y_used) begin
                     oy_ff <= '0;
                     oz_ff <= oz_ff + 1'b1;
                  end else begin
                     oy_ff <= oy_ff + 1'b1;
                  end
               end else begin
                  ox_ff <= ox_ff + 1'b1;
               end
            end
         end
      end
   end

   // control sequencer
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (fire) state_in = ST_GATHER;
         ST_GATHER: if (rd_vld_ff && rd_tag_ff == 3'(pfs_pkg::NUM_TAPS - 1))
                       state_in = ST_MATH;
         ST_MATH:   if (res.done) state_in = ST_OUT;
         ST_OUT:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_cnt_ff <= '0;
         rd_vld_ff <= 1'b0;
         start_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_en;
         start_ff  <= (state_ff == ST_GATHER) && (state_in == ST_MATH);
         if (fire) rd_cnt_ff <= '0;
         else if (rd_en) rd_cnt_ff <= rd_cnt_ff + 3'd1;
      end
   end

   // centre first, then the six neighbours, one read a cycle
   assign rd_en   = (state_ff == ST_GATHER) && (rd_cnt_ff < 3'(pfs_pkg::NUM_TAPS));
   assign rd_addr = tap_addr_ff[rd_cnt_ff];
   assign rd_temp = rd_data[pfs_pkg::ENTRY_W-1:pfs_pkg::PHASE_W];

   always_ff @(posedge clock) begin
      rd_tag_ff <= rd_cnt_ff;
      if (fire) begin
         sp_ff <= '0;
         st_ff <= '0;
      end else if (rd_vld_ff) begin
         if (rd_tag_ff == 3'd0) begin
            pc_ff <= rd_data[pfs_pkg::PHASE_W-1:0];
            tc_ff <= rd_temp;
         end else begin
            sp_ff <= sp_ff + pfs_pkg::PSUM_W'(rd_data[pfs_pkg::PHASE_W-1:0]);
            st_ff <= st_ff + pfs_pkg::TSUM_W'(rd_temp);
         end
      end
   end

   // the write lands at the accept edge, reads start the cycle after
   pfs_window_ram u_ram (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (in_addr_ff),
      .wr_data ({req_temp_old, ph_sat}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign op.start = start_ff;
   assign op.pc    = pc_ff;
   assign op.tc    = tc_ff;
   assign op.sp    = sp_ff;
   assign op.st    = st_ff;

   pfs_update u_update (
      .clock (clock),
      .reset (reset),
      .gain  (gain_ff),
      .op    (op),
      .res   (res)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_phase_ff <= res.phase;
         rsp_temp_ff  <= res.temp;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_phase_new = rsp_phase_ff;
   assign rsp_temp_new  = rsp_temp_ff;
   assign rsp_last_cell = rsp_last_ff;

endmodule

// ===== tb/sv/phase_field_stencil_step_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_field_stencil_step_tb
// self-checking bench for the streamed phase field / temperature stencil
// ----------------------------------------------------------------------------
// Grid cells and flush beats are pushed through the block for a series of
// grid shapes and gain settings, from the smallest grid to the widest rows and
// tallest planes. A cell level model of the window and the update arithmetic
// predicts every result beat; each one is compared field by field. Both sides
// idle and stall at random, with one long stretch where neither does.
// ----------------------------------------------------------------------------
module phase_field_stencil_step_tb;

   localparam int   SETTLE     = 80;    // cycles for one in-flight update
   localparam int   WATCHDOG   = 3000;  // cycles with no beat at all

   // -------------------------------------------------------------------------
   // scoreboard: window model, update arithmetic and expected result beats
   // -------------------------------------------------------------------------
   class stencil_scoreboard;
      typedef struct {
         logic [pfs_pkg::PHASE_W-1:0]       phase;
         logic signed [pfs_pkg::TEMP_W-1:0] temp;
         logic                              last;
      } cell_update_type;

      logic [pfs_pkg::ENTRY_W-1:0] window [pfs_pkg::DEPTH];
      int unsigned        in_pos, out_pos;
      int unsigned        reg_x, reg_y, reg_z;
      longint             g_thermal, g_gradient, g_potential, g_driving;
      cell_update_type    pending_updates[$];
      int                 errors, checked;

      function new();
         foreach (window[i]) window[i] = '0;
         in_pos = 0;
         out_pos = 0;
         reg_x = 64;
         reg_y = 64;
         reg_z = 64;
         g_thermal = 1870803;
         g_gradient = 2516582;
         g_potential = 496753;
         g_driving = 1581213;
         errors = 0;
         checked = 0;
      endfunction

      function int unsigned clamp_size(int unsigned v, int unsigned hi);
         if (v < 2) return 2;
         if (v > hi) return hi;
         return v;
      endfunction

      function int unsigned row_cells();
         return clamp_size(reg_x, pfs_pkg::MAX_X);
      endfunction

      function int unsigned plane_cells();
         return clamp_size(reg_x, pfs_pkg::MAX_X) * clamp_size(reg_y, pfs_pkg::MAX_Y);
      endfunction

      function int unsigned grid_cells();
         return plane_cells() * clamp_size(reg_z, pfs_pkg::MAX_Z);
      endfunction

      function void write_reg(logic [2:0] idx, logic [23:0] val);
         case (idx)
            pfs_pkg::REG_GRID_X: begin
               reg_x = val[6:0];
               in_pos = 0;
               out_pos = 0;
            end
            pfs_pkg::REG_GRID_Y: begin
               reg_y = val[6:0];
               in_pos = 0;
               out_pos = 0;
            end
            pfs_pkg::REG_GRID_Z: begin
               reg_z = val[10:0];
               in_pos = 0;
               out_pos = 0;
            end
            pfs_pkg::REG_THERMAL:   g_thermal = val;
            pfs_pkg::REG_GRADIENT:  g_gradient = val;
            pfs_pkg::REG_POTENTIAL: g_potential = val;
            pfs_pkg::REG_DRIVING:   g_driving = val;
            default: ;
         endcase
      endfunction

      // round to nearest, halves toward +infinity
      function longint round_div(longint v, int k);
         return (v + (longint'(1) << (k - 1))) >>> k;
      endfunction

      function longint int_sqrt(longint v);
         longint r, b;
         r = 0;
         b = longint'(1) << 30;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function longint phase_at(int unsigned pos);
         return longint'(window[pos % pfs_pkg::DEPTH][pfs_pkg::PHASE_W-1:0]);
      endfunction

      function longint temp_at(int unsigned pos);
         logic signed [pfs_pkg::TEMP_W-1:0] t;
         t = window[pos % pfs_pkg::DEPTH][pfs_pkg::ENTRY_W-1:pfs_pkg::PHASE_W];
         return longint'(t);
      endfunction

      function cell_update_type update_cell(int unsigned o);
         int unsigned nx, xy, total, cx, cy, cz;
         int unsigned nb[6];
         longint pc, tc, sp, st, lap_p, lap_t, t, p, s;
         cell_update_type r;
         nx = row_cells();
         xy = plane_cells();
         total = grid_cells();
         cx = o % nx;
         cy = (o / nx) % clamp_size(reg_y, pfs_pkg::MAX_Y);
         cz = o / xy;
         // zero-flux edges: outside neighbours fall back to the centre
         nb[0] = (cx > 0) ? o - 1 : o;
         nb[1] = (cx + 1 < nx) ? o + 1 : o;
         nb[2] = (cy > 0) ? o - nx : o;
         nb[3] = (cy + 1 < clamp_size(reg_y, pfs_pkg::MAX_Y)) ? o + nx : o;
         nb[4] = (cz > 0) ? o - xy : o;
         nb[5] = (cz + 1 < clamp_size(reg_z, pfs_pkg::MAX_Z)) ? o + xy : o;
         pc = phase_at(o);
         tc = temp_at(o);
         sp = 0;
         st = 0;
         foreach (nb[i]) begin
            sp += phase_at(nb[i]);
            st += temp_at(nb[i]);
         end
         lap_p = sp - 6 * pc;
         lap_t = st - 6 * tc;
         t = tc + round_div(g_thermal * lap_t, 24);
         p = pc;
         if (lap_p != 0) begin
            s = int_sqrt(pc * (65536 - pc));
            p = pc + round_div(g_gradient * lap_p, 24)
                   - round_div(g_potential * (32768 - pc), 24)
                   - round_div(g_driving * s * tc, 40);
            if (p < 0) p = 0;
            else if (p > 65536) p = 65536;
            t += p - pc;   // latent heat
         end
         if (t > 8388607) t = 8388607;
         else if (t < -8388608) t = -8388608;
         r.phase = p[pfs_pkg::PHASE_W-1:0];
         r.temp = t[pfs_pkg::TEMP_W-1:0];
         r.last = (o + 1 == total);
         return r;
      endfunction

      function void note_input(logic kind, logic [pfs_pkg::PHASE_W-1:0] ph,
                               logic [pfs_pkg::TEMP_W-1:0] tp);
         bit draining;
         draining = (in_pos == 0 && out_pos > 0);
         if (kind == pfs_pkg::KIND_CELL && !draining) begin
            if (ph > pfs_pkg::PHASE_ONE) ph = pfs_pkg::PHASE_ONE;
            window[in_pos % pfs_pkg::DEPTH] = {tp, ph};
            in_pos++;
            if (in_pos > plane_cells()) begin
               pending_updates.push_back(update_cell(out_pos));
               out_pos++;
            end
            if (in_pos >= grid_cells()) in_pos = 0;
         end else if (draining) begin
            // flush, or a cell dropped while the last plane drains
            pending_updates.push_back(update_cell(out_pos));
            out_pos++;
            if (out_pos >= grid_cells()) out_pos = 0;
         end
      endfunction

      function void check_result(logic [pfs_pkg::PHASE_W-1:0] ph,
                                 logic signed [pfs_pkg::TEMP_W-1:0] tp, logic last);
         cell_update_type e;
         if (pending_updates.size() == 0) begin
            $display("%0t: unexpected result beat phase %0d temp %0d last %0b",
                     $time, ph, tp, last);
            errors++;
            return;
         end
         e = pending_updates.pop_front();
         checked++;
         if (ph !== e.phase) begin
            $display("%0t: phase_new expected %0d actual %0d", $time, e.phase, ph);
            errors++;
         end
         if (tp !== e.temp) begin
            $display("%0t: temp_new expected %0d actual %0d", $time, e.temp, tp);
            errors++;
         end
         if (last !== e.last) begin
            $display("%0t: last_cell expected %0b actual %0b", $time, e.last, last);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // block and its ports
   // -------------------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_kind = pfs_pkg::KIND_CELL;
   logic [16:0]         req_phase_old = '0;
   logic signed [23:0]  req_temp_old = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [16:0]         rsp_phase_new;
   logic signed [23:0]  rsp_temp_new;
   logic                rsp_last_cell;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [2:0]          csr_index = pfs_pkg::REG_GRID_X;
   logic [23:0]         csr_wdata = '0;

   phase_field_stencil_step dut (.*);

   always #10 clock = ~clock;

   stencil_scoreboard sb = new();
   bit  jitter_on = 1'b1;     // random idling on both sides
   int  beats_sent = 0;       // cells and drain beats, not ignored flushes
   int  grids_run = 0;
   int  quiet_cycles = 0;

   // -------------------------------------------------------------------------
   // monitor: every accepted beat goes to the scoreboard
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall) sb.note_input(req_kind, req_phase_old, req_temp_old);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_phase_new, rsp_temp_new, rsp_last_cell);
      end
   end

   // receiver stalls about 14 beats in a hundred
   always @(posedge clock) begin
      rsp_stall <= jitter_on && ($urandom_range(99) < 14);
   end

   // watchdog on cycles with no beat on any port
   always @(posedge clock) begin
      if (reset || (csr_valid && csr_ready) || (req_valid && !req_stall)
          || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("timeout: no beat for %0d cycles", WATCHDOG);
            $display("phase_field_stencil_step_tb NOT OK");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // drivers
   // -------------------------------------------------------------------------
   task automatic send_beat(logic kind, logic [16:0] ph, logic [23:0] tp);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_phase_old <= ph;
      req_temp_old <= tp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // random sender gap
      if (jitter_on && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // hold off until every expected result is out and the pipe is empty
   task automatic drain_wait();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_updates.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [23:0] pick_gain();
      case ($urandom_range(5))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return 24'($urandom);
         default: return 24'($urandom_range(0, 4000000));
      endcase
   endfunction

   task automatic set_grid(int x, int y, int z);
      drain_wait();
      write_reg(pfs_pkg::REG_GRID_X, 24'(x));
      write_reg(pfs_pkg::REG_GRID_Y, 24'(y));
      write_reg(pfs_pkg::REG_GRID_Z, 24'(z));
      write_reg(pfs_pkg::REG_THERMAL, pick_gain());
      write_reg(pfs_pkg::REG_GRADIENT, pick_gain());
      write_reg(pfs_pkg::REG_POTENTIAL, pick_gain());
      write_reg(pfs_pkg::REG_DRIVING, pick_gain());
   endtask

   // phase styles: 0 rough, 1 sharp interfaces, 2 flat (laplacian mostly zero)
   function automatic logic [16:0] pick_phase(int style, logic [16:0] flat);
      int r;
      r = $urandom_range(19);
      case (style)
         0: return (r < 3) ? 17'($urandom_range(0, 131071)) : 17'($urandom_range(0, 65536));
         1: return (r < 8) ? 17'd0 : (r < 16) ? pfs_pkg::PHASE_ONE
                                              : 17'($urandom_range(0, 65536));
         default: return (r == 0) ? 17'($urandom_range(0, 65536)) : flat;
      endcase
   endfunction

   function automatic logic [23:0] pick_temp(int style);
      if (style == 0) return 24'($urandom);
      return 24'($signed($urandom_range(0, 131071)) - 65536);
   endfunction

   // one grid of random content; stop_at < cells gives a broken grid
   task automatic run_grid(int unsigned stop_at);
      int unsigned cells, plane;
      int pstyle, tstyle;
      logic [16:0] flat;
      cells = sb.grid_cells();
      plane = sb.plane_cells();
      pstyle = $urandom_range(2);
      tstyle = $urandom_range(1);
      flat = ($urandom_range(1)) ? 17'($urandom_range(0, 65536)) : pfs_pkg::PHASE_ONE;
      for (int unsigned i = 0; i < cells && i < stop_at; i++) begin
         // stray flush while the grid is still filling does nothing
         if ($urandom_range(29) == 0)
            send_beat(pfs_pkg::KIND_FLUSH, 17'($urandom), 24'($urandom));
         send_beat(pfs_pkg::KIND_CELL, pick_phase(pstyle, flat), pick_temp(tstyle));
         beats_sent++;
      end
      if (stop_at >= cells) begin
         // drain the last plane, cells among the flushes are dropped
         for (int unsigned i = 0; i < plane; i++) begin
            send_beat($urandom_range(1) ? pfs_pkg::KIND_FLUSH : pfs_pkg::KIND_CELL,
                      17'($urandom), 24'($urandom));
            beats_sent++;
         end
         // flush with nothing left to drain
         send_beat(pfs_pkg::KIND_FLUSH, 17'($urandom), 24'($urandom));
      end
      grids_run++;
   endtask

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: smallest grid from out-of-range sizes, gains at full scale
      write_reg(pfs_pkg::REG_GRID_X, 24'd1);
      write_reg(pfs_pkg::REG_GRID_Y, 24'd0);
      write_reg(pfs_pkg::REG_GRID_Z, 24'd2);
      write_reg(pfs_pkg::REG_THERMAL, 24'hFFFFFF);
      write_reg(pfs_pkg::REG_GRADIENT, 24'hFFFFFF);
      write_reg(pfs_pkg::REG_POTENTIAL, 24'hFFFFFF);
      write_reg(pfs_pkg::REG_DRIVING, 24'hFFFFFF);
      send_beat(pfs_pkg::KIND_FLUSH, 17'h1FFFF, 24'hFFFFFF);  // flush when idle
      send_beat(pfs_pkg::KIND_CELL, 17'd0, 24'h800000);
      send_beat(pfs_pkg::KIND_CELL, pfs_pkg::PHASE_ONE, 24'h7FFFFF);
      send_beat(pfs_pkg::KIND_FLUSH, 17'd0, 24'd0);           // flush before all cells
      send_beat(pfs_pkg::KIND_CELL, 17'h1FFFF, 24'd0);        // phase above one
      send_beat(pfs_pkg::KIND_CELL, 17'd1, 24'hFFFFFF);
      send_beat(pfs_pkg::KIND_CELL, 17'd65535, 24'h7FFFFF);
      send_beat(pfs_pkg::KIND_CELL, 17'd32768, 24'h800000);
      send_beat(pfs_pkg::KIND_CELL, 17'd0, 24'd0);
      send_beat(pfs_pkg::KIND_CELL, 17'd65537, 24'd12345);
      send_beat(pfs_pkg::KIND_CELL, 17'd7, 24'd99);          // dropped while draining
      send_beat(pfs_pkg::KIND_FLUSH, 17'd0, 24'd0);
      send_beat(pfs_pkg::KIND_CELL, 17'd0, 24'd0);
      send_beat(pfs_pkg::KIND_FLUSH, 17'd0, 24'd0);
      send_beat(pfs_pkg::KIND_FLUSH, 17'd0, 24'd0);           // idle again
      beats_sent += 12;

      // directed: gains at zero, grid 3 x 2 x 2
      drain_wait();
      write_reg(pfs_pkg::REG_GRID_X, 24'd3);
      write_reg(pfs_pkg::REG_GRID_Y, 24'd2);
      write_reg(pfs_pkg::REG_THERMAL, 24'd0);
      write_reg(pfs_pkg::REG_GRADIENT, 24'd0);
      write_reg(pfs_pkg::REG_POTENTIAL, 24'd0);
      write_reg(pfs_pkg::REG_DRIVING, 24'd0);
      run_grid(32'hFFFFFFFF);

      // widest rows and tallest planes, sizes above range saturate
      set_grid(127, 2, 2);
      run_grid(32'hFFFFFFFF);
      set_grid(2, 64, 2);
      run_grid(32'hFFFFFFFF);
      // deepest grid, only started, then cut off by the next size write
      set_grid(2, 2, 2047);
      run_grid(60);

      // random grids until enough beats have gone through
      while (beats_sent < 1250) begin
         set_grid($urandom_range(0, 6), $urandom_range(0, 5), $urandom_range(0, 4));
         // a quiet stretch with no idling on either side
         jitter_on = !(grids_run >= 6 && grids_run < 10);
         if ($urandom_range(7) == 0) begin
            run_grid($urandom_range(1, sb.grid_cells() - 1));
         end else begin
            run_grid(32'hFFFFFFFF);
         end
         // sender holds off until all results are in, then carries on
         if (grids_run == 8) drain_wait();
      end

      jitter_on = 1'b1;
      drain_wait();
      $display("covered %0d grids, %0d beats sent, %0d result beats checked",
               grids_run, beats_sent, sb.checked);
      $display("grids from 2x2x2 up to 64-wide rows, 64-row planes and 1024 planes");
      if (sb.errors == 0) begin
         $display("phase_field_stencil_step_tb OK");
      end else begin
         $display("phase_field_stencil_step_tb NOT OK");
      end
      $finish;
   end

endmodule
